/* src/bptl_pkg.sv */
// Shared types and constants for the paper tape loader.
`default_nettype none

package bptl_pkg;

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_LEADER,
        PH_SEGMENT,
        PH_DONE,
        PH_FAILED
    } phase_t;

    localparam logic [1:0] STATUS_LOADING = 2'd0;
    localparam logic [1:0] STATUS_DONE    = 2'd1;
    localparam logic [1:0] STATUS_FAILED  = 2'd2;

    // frame type held in frame bits 13:12
    localparam logic [1:0] FT_DATA   = 2'd0;
    localparam logic [1:0] FT_ORIGIN = 2'd1;
    localparam logic [1:0] FT_BAD    = 2'd2;
    localparam logic [1:0] FT_FIELD  = 2'd3;

    localparam logic [7:0]  LEADER_BYTE    = 8'o200;
    localparam logic [13:0] LEADER_FRAME   = 14'o20000;
    localparam logic [15:0] START_ADDRESS  = 16'o200;
    localparam logic [15:0] MEM_SIZE_RESET = 16'd32768;

    typedef struct packed {
        phase_t      phase;
        logic [6:0]  first_half;
        logic        half_pending;
        logic [11:0] held_frame;
        logic        held_valid;
        logic [15:0] load_address;
        logic [11:0] byte_sum;
        logic        segment_nonempty;
        logic [15:0] total_words;
        logic [15:0] segment_count;
    } state_t;

    typedef struct packed {
        logic        write_enable;
        logic [14:0] write_address;
        logic [11:0] write_data;
        logic [1:0]  load_status;
        logic [15:0] words_loaded;
        logic [15:0] segments_loaded;
    } result_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

/* src/bptl_core.sv */
// Loader state register and the per-item frame decode, checksum and store logic.
`default_nettype none

module bptl_core #(
    parameter int ADDRESS_BITS = 15
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire logic [7:0]        tape_byte,
    input  wire logic              end_of_tape,
    input  wire logic              cfg_we,
    input  wire logic [15:0]       cfg_data,
    output bptl_pkg::result_t      result
);

    localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDRESS_BITS) - 32'd1);

    bptl_pkg::state_t state_reg;
    bptl_pkg::state_t state_next;
    logic [15:0]      mem_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_size_reg <= bptl_pkg::MEM_SIZE_RESET;
        end else if (cfg_we) begin
            mem_size_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase            <= bptl_pkg::PH_SEEK;
            state_reg.first_half       <= '0;
            state_reg.half_pending     <= 1'b0;
            state_reg.held_frame       <= '0;
            state_reg.held_valid       <= 1'b0;
            state_reg.load_address     <= bptl_pkg::START_ADDRESS;
            state_reg.byte_sum         <= '0;
            state_reg.segment_nonempty <= 1'b0;
            state_reg.total_words      <= '0;
            state_reg.segment_count    <= '0;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        logic [13:0] frame;
        logic        whole;
        logic        in_segment;
        logic        frame_done;
        logic        addr_over;
        logic [11:0] chk;

        state_next            = state_reg;
        result.write_enable   = 1'b0;
        result.write_address  = '0;
        result.write_data     = '0;
        frame                 = '0;
        whole                 = 1'b0;
        in_segment            = 1'b0;
        frame_done            = 1'b0;
        addr_over             = 1'b0;
        chk                   = '0;

        if (state_reg.phase == bptl_pkg::PH_DONE || state_reg.phase == bptl_pkg::PH_FAILED) begin
            // terminal: hold
        end else if (end_of_tape) begin
            state_next.phase = (state_reg.phase == bptl_pkg::PH_LEADER) ?
                               bptl_pkg::PH_DONE : bptl_pkg::PH_FAILED;
        end else if (state_reg.phase == bptl_pkg::PH_SEEK) begin
            if (tape_byte == bptl_pkg::LEADER_BYTE) begin
                state_next.phase        = bptl_pkg::PH_LEADER;
                state_next.byte_sum     = '0;
                state_next.half_pending = 1'b0;
            end
        end else begin
            if (!state_reg.half_pending) begin
                if (tape_byte[7]) begin
                    frame = {tape_byte, 6'b0};
                    whole = 1'b1;
                end else begin
                    state_next.byte_sum     = state_reg.byte_sum + {4'b0, tape_byte};
                    state_next.first_half   = tape_byte[6:0];
                    state_next.half_pending = 1'b1;
                end
            end else begin
                state_next.byte_sum     = state_reg.byte_sum + {4'b0, tape_byte};
                frame                   = {1'b0, state_reg.first_half, tape_byte[5:0]};
                state_next.half_pending = 1'b0;
                whole                   = 1'b1;
            end

            if (whole) begin
                if (state_reg.phase == bptl_pkg::PH_LEADER) begin
                    if (frame != bptl_pkg::LEADER_FRAME) begin
                        // first non-leader frame opens a segment
                        state_next.phase            = bptl_pkg::PH_SEGMENT;
                        state_next.load_address     = bptl_pkg::START_ADDRESS;
                        state_next.segment_nonempty = 1'b0;
                        state_next.held_valid       = 1'b0;
                        in_segment                  = 1'b1;
                    end
                end else begin
                    in_segment = 1'b1;
                end
            end

            if (in_segment) begin
                if (state_next.held_valid) begin
                    state_next.held_valid = 1'b0;
                    if (frame == bptl_pkg::LEADER_FRAME) begin
                        // held word is the checksum, its own bytes taken back out
                        chk = state_next.byte_sum
                              - {6'b0, state_next.held_frame[11:6]}
                              - {6'b0, state_next.held_frame[5:0]};
                        frame_done = 1'b1;
                        if (chk != state_next.held_frame || !state_next.segment_nonempty) begin
                            state_next.phase = bptl_pkg::PH_FAILED;
                        end else begin
                            state_next.segment_count = bptl_pkg::sat_inc16(state_reg.segment_count);
                            state_next.phase         = bptl_pkg::PH_LEADER;
                            state_next.byte_sum      = '0;
                        end
                    end else begin
                        addr_over = (state_next.load_address >= mem_size_reg) ||
                                    ((state_next.load_address & ~ADDR_MASK) != 16'd0);
                        if (addr_over) begin
                            state_next.phase = bptl_pkg::PH_FAILED;
                            frame_done       = 1'b1;
                        end else begin
                            result.write_enable         = 1'b1;
                            result.write_address        = state_next.load_address[14:0];
                            result.write_data           = state_next.held_frame;
                            state_next.load_address     = state_next.load_address + 16'd1;
                            state_next.segment_nonempty = 1'b1;
                            state_next.total_words      = bptl_pkg::sat_inc16(state_reg.total_words);
                        end
                    end
                end

                if (!frame_done) begin
                    unique case (frame[13:12])
                        bptl_pkg::FT_DATA: begin
                            state_next.held_frame = frame[11:0];
                            state_next.held_valid = 1'b1;
                        end
                        bptl_pkg::FT_ORIGIN: begin
                            state_next.load_address = (state_next.load_address & 16'o70000
                                                       & ADDR_MASK) | {4'b0, frame[11:0]};
                        end
                        bptl_pkg::FT_BAD: begin
                            state_next.phase = bptl_pkg::PH_FAILED;
                        end
                        bptl_pkg::FT_FIELD: begin
                            state_next.load_address = ({1'b0, frame[11:9], 12'b0} & ADDR_MASK)
                                                      | bptl_pkg::START_ADDRESS;
                        end
                        default: begin
                            state_next.phase = bptl_pkg::PH_FAILED;
                        end
                    endcase
                end
            end
        end

        unique case (state_next.phase)
            bptl_pkg::PH_DONE:   result.load_status = bptl_pkg::STATUS_DONE;
            bptl_pkg::PH_FAILED: result.load_status = bptl_pkg::STATUS_FAILED;
            default:             result.load_status = bptl_pkg::STATUS_LOADING;
        endcase
        result.words_loaded    = state_next.total_words;
        result.segments_loaded = state_next.segment_count;
    end

endmodule

`default_nettype wire

/* src/bin_paper_tape_loader.sv */
// Paper tape absolute loader: input register, decode core and result register.
// Throughput: one item per cycle while m_ready is not held low; loader state
// updates as each item moves from the input register through the core into
// the result register.
// Reset (aresetn low, synchronous): seek first leader, counts cleared, load
// address octal 200, memory_size 32768; both pipeline stages emptied.
`default_nettype none

module bin_paper_tape_loader #(
    parameter int ADDRESS_BITS = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_tape_byte,
    input  wire logic        s_end_of_tape,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_write_enable,
    output logic [14:0]      m_write_address,
    output logic [11:0]      m_write_data,
    output logic [1:0]       m_load_status,
    output logic [15:0]      m_words_loaded,
    output logic [15:0]      m_segments_loaded,
    input  wire logic        cfg_write_enable,
    input  wire logic [15:0] cfg_write_data
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_eot_reg;
    logic               out_valid_reg;
    bptl_pkg::result_t  out_res_reg;
    bptl_pkg::result_t  core_res;
    logic               advance;

    // item moves into the result register when that register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_tape_byte;
            in_eot_reg  <= s_end_of_tape;
        end
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    bptl_core #(
        .ADDRESS_BITS(ADDRESS_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .tape_byte   (in_byte_reg),
        .end_of_tape (in_eot_reg),
        .cfg_we      (cfg_write_enable),
        .cfg_data    (cfg_write_data),
        .result      (core_res)
    );

    assign m_valid           = out_valid_reg;
    assign m_write_enable    = out_res_reg.write_enable;
    assign m_write_address   = out_res_reg.write_address;
    assign m_write_data      = out_res_reg.write_data;
    assign m_load_status     = out_res_reg.load_status;
    assign m_words_loaded    = out_res_reg.words_loaded;
    assign m_segments_loaded = out_res_reg.segments_loaded;

    // a bad code after a held word stores it and fails in the same item
    a_no_store_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_enable |-> m_load_status != bptl_pkg::STATUS_DONE)
        else $error("store reported with a done load status");

    a_idle_store_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> m_write_address == 15'd0 && m_write_data == 12'd0)
        else $error("store fields not cleared on an item without a store");

    a_done_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_load_status == bptl_pkg::STATUS_DONE
        |=> !m_valid || (m_load_status == bptl_pkg::STATUS_DONE && !m_write_enable))
        else $error("load status left done");

    a_failed_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_load_status == bptl_pkg::STATUS_FAILED
        |=> !m_valid || (m_load_status == bptl_pkg::STATUS_FAILED && !m_write_enable))
        else $error("load status left failed");

endmodule

`default_nettype wire
